// ===== rtl/core/id3u8_pkg.sv =====
package id3u8_pkg;

    // Counter width default and fixed field widths
    localparam int COUNT_BITS_DEF = 16;
    localparam int CAP_W          = 16;
    localparam int ENC_W          = 2;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 16;

    // Input encodings
    localparam logic [ENC_W-1:0] ENC_LATIN1   = 2'd0;
    localparam logic [ENC_W-1:0] ENC_UTF16_LE = 2'd1;
    localparam logic [ENC_W-1:0] ENC_UTF16_BE = 2'd2;
    localparam logic [ENC_W-1:0] ENC_RAW      = 2'd3;

    // Halt reasons reported on the closing result
    localparam logic [1:0] HALT_EXHAUSTED = 2'd0;
    localparam logic [1:0] HALT_NUL       = 2'd1;
    localparam logic [1:0] HALT_FULL      = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ENCODING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY  = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'd2048;

    // Work queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int REC_BYTES   = 7;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       byte_valid;
        logic       end_of_text;
        logic [1:0] halt_reason;
    } result_t;

    // One encoded character: bytes[0] goes out first
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } utf8_seq_t;

    // All results caused by one input byte
    typedef struct packed {
        logic [REC_BYTES-1:0][7:0] data;
        logic [2:0]                n_data;
        logic                      end_mark;
        logic [1:0]                reason;
    } work_t;

    function automatic utf8_seq_t utf8_encode(input logic [20:0] cp);
        utf8_seq_t s;
        s.bytes = '0;
        if (cp <= 21'h7F) begin
            s.bytes[0] = cp[7:0];
            s.len      = 3'd1;
        end
        else if (cp <= 21'h7FF) begin
            s.bytes[0] = {3'b110, cp[10:6]};
            s.bytes[1] = {2'b10, cp[5:0]};
            s.len      = 3'd2;
        end
        else if (cp <= 21'hFFFF) begin
            s.bytes[0] = {4'b1110, cp[15:12]};
            s.bytes[1] = {2'b10, cp[11:6]};
            s.bytes[2] = {2'b10, cp[5:0]};
            s.len      = 3'd3;
        end
        else begin
            s.bytes[0] = {5'b11110, cp[20:18]};
            s.bytes[1] = {2'b10, cp[17:12]};
            s.bytes[2] = {2'b10, cp[11:6]};
            s.bytes[3] = {2'b10, cp[5:0]};
            s.len      = 3'd4;
        end
        return s;
    endfunction

    // Printable, or one of TAB, LF, CR
    function automatic logic is_kept(input logic [15:0] cp);
        return (cp >= 16'h20) || (cp == 16'h09) || (cp == 16'h0A) || (cp == 16'h0D);
    endfunction

endpackage

// ===== rtl/core/id3u8_front.sv =====
module id3u8_front
    import id3u8_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  in_item_t         item,
    input  logic [ENC_W-1:0] text_encoding,
    input  logic [CAP_W-1:0] out_capacity,
    output work_t            work,
    output logic             work_valid
);

    localparam int SUM_W = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 1;

    // Per-text decoder state
    logic [7:0]            lead_reg, lead_next;
    logic                  phase_reg, phase_next;
    logic                  first_reg, first_next;
    logic                  be_reg, be_next;
    logic [9:0]            held_reg, held_next;
    logic                  pend_reg, pend_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  halted_reg, halted_next;
    logic [1:0]            cause_reg, cause_next;

    logic            utf16, unit_go, bom_le, bom_be, drop_bom, be_eff;
    logic            is_low, is_high;
    logic [15:0]     unit;
    logic            a_en, b_en, nul_req;
    utf8_seq_t       a_seq, b_seq;
    logic            pend_after;
    logic [9:0]      held_after;
    logic [SUM_W-1:0] sum_a, sum_b, cap_ext, count1;
    logic            a_ok, b_ok, a_out, b_out, a_fail, b_try, b_fail, nul_do, halt_now;
    logic [2:0]      a_n, b_n;
    logic [1:0]      cause_after;

    // Classify the byte and pick up to two characters to emit
    always_comb
    begin
        utf16    = (text_encoding == ENC_UTF16_LE) || (text_encoding == ENC_UTF16_BE);
        unit_go  = utf16 && phase_reg && !halted_reg;
        bom_le   = (lead_reg == 8'hFF) && (item.in_byte == 8'hFE);
        bom_be   = (lead_reg == 8'hFE) && (item.in_byte == 8'hFF);
        drop_bom = first_reg && (bom_le || bom_be);
        if (first_reg)
        begin
            be_eff = bom_le ? 1'b0 : (bom_be ? 1'b1 : (text_encoding == ENC_UTF16_BE));
        end
        else
        begin
            be_eff = be_reg;
        end
        unit    = be_eff ? {lead_reg, item.in_byte} : {item.in_byte, lead_reg};
        is_low  = (unit[15:10] == 6'b110111);
        is_high = (unit[15:10] == 6'b110110);

        a_en       = 1'b0;
        b_en       = 1'b0;
        nul_req    = 1'b0;
        a_seq      = utf8_encode(21'h0);
        b_seq      = utf8_encode(21'h0);
        pend_after = pend_reg;
        held_after = held_reg;

        if (!halted_reg)
        begin
            if (utf16)
            begin
                if (unit_go && !drop_bom)
                begin
                    // Resolve a held high surrogate first
                    if (pend_reg)
                    begin
                        pend_after = 1'b0;
                        a_en       = 1'b1;
                        if (is_low)
                        begin
                            a_seq = utf8_encode(21'h10000 + 21'({held_reg, unit[9:0]}));
                        end
                        else
                        begin
                            a_seq = utf8_encode({5'b0, 6'b110110, held_reg});
                        end
                    end
                    if (!(pend_reg && is_low))
                    begin
                        if (unit == 16'h0)
                        begin
                            nul_req = 1'b1;
                        end
                        else if (is_high)
                        begin
                            pend_after = 1'b1;
                            held_after = unit[9:0];
                        end
                        else if (is_kept(unit))
                        begin
                            b_en  = 1'b1;
                            b_seq = utf8_encode({5'b0, unit});
                        end
                    end
                end
                // A high surrogate still held at the final byte goes out alone
                if (item.last_byte && pend_after)
                begin
                    b_en       = 1'b1;
                    b_seq      = utf8_encode({5'b0, 6'b110110, held_after});
                    pend_after = 1'b0;
                end
            end
            else
            begin
                pend_after = 1'b0;
                if (item.in_byte == 8'h0)
                begin
                    nul_req = 1'b1;
                end
                else if (is_kept({8'h0, item.in_byte}))
                begin
                    b_en = 1'b1;
                    if (text_encoding == ENC_RAW)
                    begin
                        b_seq          = utf8_encode(21'h0);
                        b_seq.bytes[0] = item.in_byte;
                    end
                    else
                    begin
                        b_seq = utf8_encode({13'b0, item.in_byte});
                    end
                end
            end
        end
    end

    // Capacity checks, one per character, in order
    always_comb
    begin
        cap_ext = SUM_W'(out_capacity);
        sum_a   = SUM_W'(count_reg) + SUM_W'(a_seq.len);
        a_ok    = (sum_a < cap_ext) && (sum_a[SUM_W-1:COUNT_BITS] == '0);
        a_out   = a_en && a_ok;
        a_fail  = a_en && !a_ok;
        count1  = a_out ? sum_a : SUM_W'(count_reg);
        nul_do  = nul_req && !a_fail;
        b_try   = b_en && !a_fail && !nul_req;
        sum_b   = count1 + SUM_W'(b_seq.len);
        b_ok    = (sum_b < cap_ext) && (sum_b[SUM_W-1:COUNT_BITS] == '0);
        b_out   = b_try && b_ok;
        b_fail  = b_try && !b_ok;
        halt_now    = a_fail || nul_do || b_fail;
        cause_after = halt_now ? (nul_do ? HALT_NUL : HALT_FULL) : cause_reg;
        a_n = a_out ? a_seq.len : 3'd0;
        b_n = b_out ? b_seq.len : 3'd0;
    end

    // Pack the emitted bytes back to back into one record
    always_comb
    begin
        work.data = '0;
        for (int i = 0; i < REC_BYTES; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if ((a_n > 3'(j)) && (i == j))
                begin
                    work.data[i] = a_seq.bytes[j];
                end
                if ((b_n > 3'(j)) && (({1'b0, a_n} + 4'(j)) == 4'(i)))
                begin
                    work.data[i] = b_seq.bytes[j];
                end
            end
        end
        work.n_data   = a_n + b_n;
        work.end_mark = item.last_byte;
        work.reason   = (halted_reg || halt_now) ? cause_after : HALT_EXHAUSTED;
        work_valid    = fire && ((work.n_data != 3'd0) || item.last_byte);
    end

    // Next state
    always_comb
    begin
        lead_next   = lead_reg;
        phase_next  = phase_reg;
        first_next  = first_reg;
        be_next     = be_reg;
        held_next   = held_reg;
        pend_next   = pend_reg;
        count_next  = count_reg;
        halted_next = halted_reg;
        cause_next  = cause_reg;
        if (fire)
        begin
            if (item.last_byte)
            begin
                lead_next   = 8'h0;
                phase_next  = 1'b0;
                first_next  = 1'b1;
                be_next     = 1'b0;
                held_next   = 10'h0;
                pend_next   = 1'b0;
                count_next  = '0;
                halted_next = 1'b0;
                cause_next  = HALT_EXHAUSTED;
            end
            else if (!halted_reg)
            begin
                if (utf16)
                begin
                    if (!phase_reg)
                    begin
                        lead_next  = item.in_byte;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        if (first_reg)
                        begin
                            first_next = 1'b0;
                            be_next    = be_eff;
                        end
                    end
                end
                held_next   = held_after;
                pend_next   = pend_after;
                count_next  = b_out ? COUNT_BITS'(sum_b) : COUNT_BITS'(count1);
                halted_next = halt_now;
                cause_next  = cause_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg   <= 8'h0;
            phase_reg  <= 1'b0;
            first_reg  <= 1'b1;
            be_reg     <= 1'b0;
            held_reg   <= 10'h0;
            pend_reg   <= 1'b0;
            count_reg  <= '0;
            halted_reg <= 1'b0;
            cause_reg  <= HALT_EXHAUSTED;
        end
        else
        begin
            lead_reg   <= lead_next;
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            be_reg     <= be_next;
            held_reg   <= held_next;
            pend_reg   <= pend_next;
            count_reg  <= count_next;
            halted_reg <= halted_next;
            cause_reg  <= cause_next;
        end
    end

endmodule

// ===== rtl/core/id3u8_queue.sv =====
module id3u8_queue
    import id3u8_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  work_t wr_data,
    output logic  full,
    input  logic  rd_en,
    output work_t rd_data,
    output logic  empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    work_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/id3u8_back.sv =====
module id3u8_back
    import id3u8_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  work_t   q_data,
    output logic    q_pop,
    output result_t result,
    output logic    empty,
    input  logic    pop
);

    work_t      cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [2:0] pos_reg, pos_next;
    result_t    out_reg, out_next;
    logic       out_valid_reg, out_valid_next;

    logic       out_free, step, done;
    logic [3:0] total;
    result_t    item_now;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    // Result for the current position of the record
    always_comb
    begin
        total = {1'b0, cur_reg.n_data} + {3'b0, cur_reg.end_mark};
        if (pos_reg < cur_reg.n_data)
        begin
            item_now.utf8_byte   = cur_reg.data[pos_reg];
            item_now.byte_valid  = 1'b1;
            item_now.end_of_text = 1'b0;
            item_now.halt_reason = HALT_EXHAUSTED;
        end
        else
        begin
            item_now.utf8_byte   = 8'h0;
            item_now.byte_valid  = 1'b0;
            item_now.end_of_text = 1'b1;
            item_now.halt_reason = cur_reg.reason;
        end
    end

    // Serializer: one result per cycle while out_reg is free; next record loads as the last one leaves
    always_comb
    begin
        out_free = !out_valid_reg || pop;
        step     = cur_valid_reg && out_free;
        done     = step && (({1'b0, pos_reg} + 4'd1) == total);
        q_pop    = (!cur_valid_reg || done) && !q_empty;

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        pos_next       = pos_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (q_pop)
        begin
            cur_next       = q_data;
            cur_valid_next = 1'b1;
            pos_next       = 3'd0;
        end
        else if (done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (step)
        begin
            pos_next = pos_reg + 3'd1;
        end

        if (step)
        begin
            out_next       = item_now;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

endmodule

// ===== rtl/core/id3_text_to_utf8_top.sv =====
// Text field to UTF-8 transcoder. One raw byte of the field is taken per cycle
// whenever full is low; the front decodes it (Latin-1, UTF-16 with byte order
// mark detection and surrogate pairing, or raw copy), applies the capacity
// limit and writes everything the byte produces, up to seven results, as one
// record into a four-entry work queue. The back end drains that queue one
// result per cycle into an output register while that register is free,
// and input stalls only when the queue fills. A byte marked last always
// gives a closing result with end_of_text set and the halt reason. Write
// text_encoding and out_capacity only while idle; cfg_ready is always high.
// There is no start-up clearing pass.
module id3_text_to_utf8_top
    import id3u8_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  in_item_t              item,
    output logic                  empty,
    input  logic                  pop,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [ENC_W-1:0] enc_reg, enc_next;
    logic [CAP_W-1:0] cap_reg, cap_next;

    logic  fire, work_valid, q_empty, q_pop;
    work_t work, q_data;

    assign cfg_ready = 1'b1;
    assign fire      = push && !full;

    // Configuration registers
    always_comb
    begin
        enc_next = enc_reg;
        cap_next = cap_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TEXT_ENCODING: enc_next = cfg_data[ENC_W-1:0];
                REG_OUT_CAPACITY:  cap_next = cfg_data[CAP_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg <= ENC_LATIN1;
            cap_reg <= CAP_RESET;
        end
        else
        begin
            enc_reg <= enc_next;
            cap_reg <= cap_next;
        end
    end

    id3u8_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .item          (item),
        .text_encoding (enc_reg),
        .out_capacity  (cap_reg),
        .work          (work),
        .work_valid    (work_valid)
    );

    id3u8_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (work_valid),
        .wr_data (work),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    id3u8_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule
